@@ design/jbhc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jbhc_pkg;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_COMPONENTS = 4;
    localparam int DEFAULT_COEFF_BITS = 12;

    // Fixed geometry of the coder.
    localparam int FIELD_BITS   = 12;
    localparam int BLOCK_SIZE   = 64;
    localparam int POS_W        = 6;
    localparam int RUN_W        = 6;
    localparam int DC_CATS      = 13;
    localparam int DC_SLOTS     = 16;
    localparam int AC_SYMS      = 256;
    localparam int MAX_CODE_LEN = 16;
    localparam int BITS_W       = 28;
    localparam int CNT_W        = 5;

    localparam logic [7:0] ZRL_SYMBOL = 8'hF0;
    localparam logic [7:0] EOB_SYMBOL = 8'h00;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // Input actions.
    localparam logic [1:0] ACT_CODE     = 2'd0;
    localparam logic [1:0] ACT_DC_WRITE = 2'd1;
    localparam logic [1:0] ACT_AC_WRITE = 2'd2;
    localparam logic [1:0] ACT_CLEAR    = 2'd3;

    // Kind of the main result of a coded coefficient.
    localparam logic [1:0] KIND_DC  = 2'd0;
    localparam logic [1:0] KIND_AC  = 2'd1;
    localparam logic [1:0] KIND_EOB = 2'd2;

    typedef struct packed {
        logic [4:0]  len;
        logic [15:0] code;
    } entry_t;

    typedef struct packed {
        logic       valid;
        logic       has_result;
        logic [1:0] kind;
        logic [3:0] nb;
        logic [11:0] extra;
        logic [1:0] zrl_cnt;
        entry_t     zrl;
    } info_t;

    typedef struct packed {
        logic [1:0]        zrl_cnt;
        logic [BITS_W-1:0] zrl_bits;
        logic [CNT_W-1:0]  zrl_count;
        logic              zrl_missing;
        logic [BITS_W-1:0] main_bits;
        logic [CNT_W-1:0]  main_count;
        logic              main_missing;
    } bundle_t;

    // Number of significant bits of a magnitude.
    function automatic logic [3:0] category(input logic [11:0] m);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 12; i++)
        begin
            if (m[i])
            begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [15:0] code_mask(input logic [4:0] len);
        logic [15:0] m;
        for (int i = 0; i < 16; i++)
        begin
            m[i] = 5'(i) < len;
        end
        return m;
    endfunction

    function automatic logic [11:0] extra_mask(input logic [3:0] nb);
        logic [11:0] m;
        for (int i = 0; i < 12; i++)
        begin
            m[i] = 4'(i) < nb;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ design/jpeg_baseline_huffman_block_coder.sv @@
// Baseline JPEG Huffman coder. Each input item is either one quantized coefficient in
// zigzag order (DC first in every block of 64), a DC or AC table entry write, or a clear
// of the DC predictors. A coefficient item gives zero to four output items, each a
// right-aligned bit string with its length: a DC code, up to three ZRL codes followed by
// an AC run/size code, or an EOB; tlast marks the final one of an input item, and tuser
// flags a missing table entry. One input item is accepted per clock cycle while s_tready
// is high; the table lookup is registered in the code RAMs, and each result then passes
// through a four-entry queue of per-item results before it is offered on the output.
// Sustained rate is one item per cycle while items give at most one result each and
// m_tready stays high. After reset every entry of both tables is cleared to length zero,
// and s_tready stays low during that sweep.
`timescale 1ns / 1ps
`default_nettype none

module jpeg_baseline_huffman_block_coder import jbhc_pkg::*; #(
    parameter int COMPONENTS = DEFAULT_COMPONENTS,
    parameter int COEFF_BITS = DEFAULT_COEFF_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // coefficient[11:0], symbol[19:12], code_length[24:20], code_bits[40:25], zero pad
    input  wire logic [47:0] s_tdata,
    // action[1:0], component[3:2]
    input  wire logic [3:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // bits[27:0], bit_count[32:28], zero pad
    output logic [39:0]      m_tdata,
    // missing_code
    output logic             m_tuser,
    output logic             m_tlast
);

    localparam int DC_AW = $clog2(COMPONENTS * DC_SLOTS);
    localparam int AC_AW = $clog2(COMPONENTS * AC_SYMS);

    logic                         clearing;
    logic [QC_W-1:0]              q_count;
    logic                         dc_we;
    logic [DC_AW-1:0]             dc_waddr;
    logic [DC_AW-1:0]             dc_raddr;
    entry_t                       dc_wdata;
    entry_t                       dc_rdata;
    logic                         ac_we;
    logic [AC_AW-1:0]             ac_waddr;
    logic [AC_AW-1:0]             ac_raddr;
    entry_t                       ac_wdata;
    entry_t                       ac_rdata;
    info_t                        info;
    logic [BITS_W-1:0]            result_bits;
    logic [CNT_W-1:0]             result_count;
    logic                         result_missing;
    logic signed [FIELD_BITS-1:0] coefficient;

    assign coefficient = s_tdata[11:0];

    jbhc_front #(
        .COMPONENTS (COMPONENTS),
        .COEFF_BITS (COEFF_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .action      (s_tuser[1:0]),
        .component   (s_tuser[3:2]),
        .coefficient (coefficient),
        .symbol      (s_tdata[19:12]),
        .code_length (s_tdata[24:20]),
        .code_bits   (s_tdata[40:25]),
        .q_count     (q_count),
        .clearing    (clearing),
        .dc_we       (dc_we),
        .dc_waddr    (dc_waddr),
        .dc_wdata    (dc_wdata),
        .dc_raddr    (dc_raddr),
        .ac_we       (ac_we),
        .ac_waddr    (ac_waddr),
        .ac_wdata    (ac_wdata),
        .ac_raddr    (ac_raddr),
        .info        (info)
    );

    jbhc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (COMPONENTS * DC_SLOTS)
    ) u_dc_ram (
        .clk   (clk),
        .we    (dc_we),
        .waddr (dc_waddr),
        .wdata (dc_wdata),
        .raddr (dc_raddr),
        .rdata (dc_rdata)
    );

    jbhc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (COMPONENTS * AC_SYMS)
    ) u_ac_ram (
        .clk   (clk),
        .we    (ac_we),
        .waddr (ac_waddr),
        .wdata (ac_wdata),
        .raddr (ac_raddr),
        .rdata (ac_rdata)
    );

    jbhc_outq u_outq (
        .clk            (clk),
        .rst_n          (rst_n),
        .info           (info),
        .dc_rdata       (dc_rdata),
        .ac_rdata       (ac_rdata),
        .q_count        (q_count),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .result_bits    (result_bits),
        .result_count   (result_count),
        .result_missing (result_missing),
        .m_tlast        (m_tlast)
    );

    assign m_tdata = {7'd0, result_count, result_bits};
    assign m_tuser = result_missing;

    // No item is taken while the tables are being swept.
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !s_tready)
        else $error("input accepted during table clear");

    // A ZRL item carries only its code, so it is flagged exactly when it is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == (m_tdata[32:28] == 5'd0))
        else $error("ZRL item length and missing flag disagree");

    // With the code missing, only the extra bits of at most category twelve remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && m_tlast |-> m_tdata[32:28] <= 5'd12)
        else $error("missing code item longer than its extra bits");

    // A ZRL item is always followed by the run/size item of the same coefficient.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("run/size item not pending after a ZRL item");

endmodule

`default_nettype wire

@@ design/jbhc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jbhc_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/jbhc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jbhc_front import jbhc_pkg::*; #(
    parameter int COMPONENTS = DEFAULT_COMPONENTS,
    parameter int COEFF_BITS = DEFAULT_COEFF_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [1:0]                            action,
    input  wire logic [1:0]                            component,
    input  wire logic signed [FIELD_BITS-1:0]          coefficient,
    input  wire logic [7:0]                            symbol,
    input  wire logic [4:0]                            code_length,
    input  wire logic [15:0]                           code_bits,
    input  wire logic [QC_W-1:0]                       q_count,
    output logic                                       clearing,
    output logic                                       dc_we,
    output logic [$clog2(COMPONENTS * DC_SLOTS)-1:0]   dc_waddr,
    output entry_t                                     dc_wdata,
    output logic [$clog2(COMPONENTS * DC_SLOTS)-1:0]   dc_raddr,
    output logic                                       ac_we,
    output logic [$clog2(COMPONENTS * AC_SYMS)-1:0]    ac_waddr,
    output entry_t                                     ac_wdata,
    output logic [$clog2(COMPONENTS * AC_SYMS)-1:0]    ac_raddr,
    output info_t                                      info
);

    localparam int CW       = COMPONENTS > 1 ? $clog2(COMPONENTS) : 1;
    localparam int DC_AW    = $clog2(COMPONENTS * DC_SLOTS);
    localparam int AC_AW    = $clog2(COMPONENTS * AC_SYMS);
    localparam int AC_DEPTH = COMPONENTS * AC_SYMS;
    localparam int SAT_W    = COEFF_BITS < FIELD_BITS ? COEFF_BITS : FIELD_BITS;

    localparam logic [2:0]                   COMP_LIMIT = 3'(COMPONENTS);
    localparam logic [CW-1:0]                COMP_LAST  = CW'(COMPONENTS - 1);
    localparam logic signed [FIELD_BITS-1:0] SAT_HI = FIELD_BITS'((1 << (SAT_W - 1)) - 1);
    localparam logic signed [FIELD_BITS-1:0] SAT_LO = FIELD_BITS'(-(1 << (SAT_W - 1)));
    localparam logic [AC_AW-1:0]             CLR_LAST = AC_AW'(AC_DEPTH - 1);

    logic signed [FIELD_BITS-1:0] pred_reg  [COMPONENTS];
    logic signed [FIELD_BITS-1:0] pred_next [COMPONENTS];
    entry_t                       zrl_reg   [COMPONENTS];
    entry_t                       zrl_next  [COMPONENTS];
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [RUN_W-1:0]             run_reg, run_next;
    logic                         clearing_reg, clearing_next;
    logic [AC_AW-1:0]             clr_cnt_reg, clr_cnt_next;
    info_t                        info_reg, info_next;

    logic                         accept;
    logic [CW-1:0]                comp_eff;
    logic [4:0]                   len_clamped;
    entry_t                       wr_entry;
    logic signed [FIELD_BITS-1:0] c_sat;
    logic signed [FIELD_BITS-1:0] pred_cur;
    logic                         at_dc;
    logic                         at_end;
    logic signed [FIELD_BITS:0]   diff;
    logic signed [FIELD_BITS:0]   val;
    logic signed [FIELD_BITS:0]   mag_full;
    logic signed [FIELD_BITS:0]   ones;
    logic [3:0]                   nb;
    logic [11:0]                  extra;
    logic [1:0]                   kind;
    logic [7:0]                   ac_sym_rd;
    logic [CW+3:0]                dc_full_r;
    logic [CW+3:0]                dc_full_w;
    logic [CW+7:0]                ac_full_r;
    logic [CW+7:0]                ac_full_w;
    logic [QC_W-1:0]              occupancy;

    assign accept    = s_tvalid && s_tready;
    assign occupancy = q_count + QC_W'(info_reg.valid);
    assign s_tready  = !clearing_reg && (occupancy < QC_W'(QUEUE_DEPTH));
    assign clearing  = clearing_reg;
    assign info      = info_reg;

    assign comp_eff    = ({1'b0, component} >= COMP_LIMIT) ? COMP_LAST : component[CW-1:0];
    assign len_clamped = (code_length > 5'(MAX_CODE_LEN)) ? 5'(MAX_CODE_LEN) : code_length;
    assign wr_entry    = '{len: len_clamped, code: code_bits};

    always_comb
    begin
        if (coefficient > SAT_HI)
        begin
            c_sat = SAT_HI;
        end
        else if (coefficient < SAT_LO)
        begin
            c_sat = SAT_LO;
        end
        else
        begin
            c_sat = coefficient;
        end
    end

    assign pred_cur = pred_reg[comp_eff];
    assign at_dc    = pos_reg == '0;
    assign at_end   = pos_reg == POS_W'(BLOCK_SIZE - 1);

    // The DC term codes its difference from the predictor, an AC term itself.
    assign diff     = {c_sat[FIELD_BITS-1], c_sat} - {pred_cur[FIELD_BITS-1], pred_cur};
    assign val      = at_dc ? diff : {c_sat[FIELD_BITS-1], c_sat};
    assign mag_full = val[FIELD_BITS] ? -val : val;
    assign nb       = category(mag_full[11:0]);
    assign ones     = val[FIELD_BITS] ? val - 13'sd1 : val;
    assign extra    = ones[11:0] & extra_mask(nb);

    always_comb
    begin
        if (at_dc)
        begin
            kind = KIND_DC;
        end
        else if (c_sat == '0)
        begin
            kind = KIND_EOB;
        end
        else
        begin
            kind = KIND_AC;
        end
    end

    assign ac_sym_rd = (kind == KIND_EOB) ? EOB_SYMBOL : {run_reg[3:0], nb};
    assign dc_full_r = {comp_eff, nb};
    assign dc_full_w = {comp_eff, symbol[3:0]};
    assign ac_full_r = {comp_eff, ac_sym_rd};
    assign ac_full_w = {comp_eff, symbol};

    assign dc_raddr = dc_full_r[DC_AW-1:0];
    assign ac_raddr = ac_full_r[AC_AW-1:0];

    assign dc_we    = clearing_reg ||
                      (accept && action == ACT_DC_WRITE && symbol < 8'(DC_CATS));
    assign dc_waddr = clearing_reg ? clr_cnt_reg[DC_AW-1:0] : dc_full_w[DC_AW-1:0];
    assign dc_wdata = clearing_reg ? '0 : wr_entry;
    assign ac_we    = clearing_reg || (accept && action == ACT_AC_WRITE);
    assign ac_waddr = clearing_reg ? clr_cnt_reg : ac_full_w[AC_AW-1:0];
    assign ac_wdata = clearing_reg ? '0 : wr_entry;

    always_comb
    begin
        info_next.valid      = accept;
        info_next.has_result = accept && action == ACT_CODE &&
                               (at_dc || c_sat != '0 || at_end);
        info_next.kind       = kind;
        info_next.nb         = nb;
        info_next.extra      = extra;
        info_next.zrl_cnt    = (kind == KIND_AC) ? run_reg[5:4] : 2'd0;
        info_next.zrl        = zrl_reg[comp_eff];
    end

    always_comb
    begin
        pos_next  = pos_reg;
        run_next  = run_reg;
        pred_next = pred_reg;
        zrl_next  = zrl_reg;
        if (accept)
        begin
            unique case (action)
                ACT_CODE:
                begin
                    pos_next = pos_reg + POS_W'(1);
                    if (at_dc)
                    begin
                        pred_next[comp_eff] = c_sat;
                        run_next = '0;
                    end
                    else if (c_sat == '0)
                    begin
                        run_next = at_end ? '0 : run_reg + RUN_W'(1);
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                ACT_DC_WRITE:
                begin
                    pos_next = pos_reg;
                end
                ACT_AC_WRITE:
                begin
                    if (symbol == ZRL_SYMBOL)
                    begin
                        zrl_next[comp_eff] = wr_entry;
                    end
                end
                ACT_CLEAR:
                begin
                    for (int i = 0; i < COMPONENTS; i++)
                    begin
                        pred_next[i] = '0;
                    end
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    // After reset every table entry is swept to length zero.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AC_AW'(1);
            if (clr_cnt_reg == CLR_LAST)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            run_reg      <= '0;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            info_reg     <= '0;
            for (int i = 0; i < COMPONENTS; i++)
            begin
                pred_reg[i] <= '0;
                zrl_reg[i]  <= '0;
            end
        end
        else
        begin
            pos_reg      <= pos_next;
            run_reg      <= run_next;
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            info_reg     <= info_next;
            pred_reg     <= pred_next;
            zrl_reg      <= zrl_next;
        end
    end

endmodule

`default_nettype wire

@@ design/jbhc_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jbhc_outq import jbhc_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire info_t             info,
    input  wire entry_t            dc_rdata,
    input  wire entry_t            ac_rdata,
    output logic [QC_W-1:0]        q_count,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BITS_W-1:0]      result_bits,
    output logic [CNT_W-1:0]       result_count,
    output logic                   result_missing,
    output logic                   m_tlast
);

    bundle_t           q_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0]   count_reg, count_next;
    logic [1:0]        sub_reg, sub_next;

    entry_t            main_e;
    logic [15:0]       main_code;
    logic [15:0]       zrl_code;
    bundle_t           bundle;
    bundle_t           head;
    logic              push;
    logic              fire;
    logic              at_main;
    logic              pop;

    // Assemble the Huffman code and the extra bits of one coded coefficient.
    assign main_e    = (info.kind == KIND_DC) ? dc_rdata : ac_rdata;
    assign main_code = main_e.code & code_mask(main_e.len);
    assign zrl_code  = info.zrl.code & code_mask(info.zrl.len);

    always_comb
    begin
        bundle.zrl_cnt      = info.zrl_cnt;
        bundle.zrl_bits     = BITS_W'(zrl_code);
        bundle.zrl_count    = info.zrl.len;
        bundle.zrl_missing  = info.zrl.len == '0;
        bundle.main_bits    = (BITS_W'(main_code) << info.nb) | BITS_W'(info.extra);
        bundle.main_count   = main_e.len + CNT_W'(info.nb);
        bundle.main_missing = main_e.len == '0;
    end

    assign push    = info.valid && info.has_result;
    assign head    = q_reg[rd_ptr_reg];
    assign at_main = sub_reg == head.zrl_cnt;
    assign fire    = m_tvalid && m_tready;
    assign pop     = fire && at_main;

    assign q_count        = count_reg;
    assign m_tvalid       = count_reg != '0;
    assign m_tlast        = at_main;
    assign result_bits    = at_main ? head.main_bits : head.zrl_bits;
    assign result_count   = at_main ? head.main_count : head.zrl_count;
    assign result_missing = at_main ? head.main_missing : head.zrl_missing;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QP_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QP_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QC_W'(push) - QC_W'(pop);
        sub_next    = sub_reg;
        if (fire)
        begin
            sub_next = at_main ? 2'd0 : sub_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

endmodule

`default_nettype wire
